>>> rtl/core/signed_int_to_decimal_ascii_macros.svh
// assertion macros for the decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// antecedent holds, consequent must hold on the next clock
`define SIDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent holds, consequent must hold on the same clock
`define SIDA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sida_pkg.sv
// constants and helpers for the decimal text converter
`default_nettype none

package sida_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // decimal digits needed for the largest magnitude, 2^(bits-1)
  function automatic int dec_digits(input int bits);
    logic [64:0] v;
    int          n;
    v = 65'd1 << (bits - 1);
    n = 0;
    while (v != 65'd0) begin
      v = v / 10;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/signed_int_to_decimal_ascii.sv
// signed binary to decimal ascii text converter, top level
//
// Converts a signed two's complement value into its decimal text, one character per
// strobe, most significant first, with a leading '-' for negative values and no
// leading zeros. A value is taken when start is high and busy is low. The magnitude
// passes through a sign and magnitude stage and VALUE_BITS shift-and-add-3 stages,
// one input bit each, VALUE_BITS + 1 register stages in all. The serialiser and its
// output register add two more before the first character appears. Characters then
// leave at one per cycle from a single character serialiser, and the text of each value
// is 1 to 11 characters long at 32 bits. The serialiser sets the sustained rate; the
// pipeline buffers up to VALUE_BITS + 1 further values and busy rises only when it is
// full. The receiver cannot stall: every strobe is a transfer.
`default_nettype none

`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output      logic                         strobe,
  output      logic [6:0]                   ascii_char,
  output      logic                         last_char
);

  localparam int DIGITS = sida_pkg::dec_digits(VALUE_BITS);
  localparam int BCD_W  = 4 * DIGITS;
  localparam int IDX_W  = $clog2(DIGITS);
  localparam int STAGES = VALUE_BITS + 1;

  // pipeline stage registers
  logic [BCD_W-1:0]      bcd_q [STAGES];
  logic [VALUE_BITS-1:0] mag_q [STAGES];
  logic [STAGES-1:0]     neg_q;
  logic [STAGES-1:0]     vld_q;
  logic [STAGES:0]       ready;

  // serialiser state
  logic             active;
  logic             sign_pend;
  logic [BCD_W-1:0] ser_bcd;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] lead;
  logic             emit_last;
  logic [3:0]       cur_digit;
  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag_in;
  logic             accept;

  assign accept    = start && !busy;
  assign value_u   = value;
  assign mag_in    = value_u[VALUE_BITS-1] ? (~value_u + 1'b1) : value_u;
  assign emit_last = active && !sign_pend && (idx == '0);
  assign ready[STAGES] = !active || emit_last;
  assign busy      = !ready[0];
  assign cur_digit = ser_bcd[idx*4 +: 4];

  for (genvar k = 0; k < STAGES; k++) begin : g_ready
    assign ready[k] = !vld_q[k] || ready[k+1];
  end

  // sign and magnitude stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (ready[0]) begin
      vld_q[0] <= accept;
    end
    if (ready[0] && accept) begin
      bcd_q[0] <= '0;
      mag_q[0] <= mag_in;
      neg_q[0] <= value_u[VALUE_BITS-1];
    end
  end

  // shift-and-add-3 stages, one magnitude bit each
  for (genvar s = 1; s < STAGES; s++) begin : g_dabble
    logic [BCD_W-1:0] corr;

    always_comb begin
      for (int j = 0; j < DIGITS; j++) begin
        if (bcd_q[s-1][j*4 +: 4] >= 4'd5) begin
          corr[j*4 +: 4] = bcd_q[s-1][j*4 +: 4] + 4'd3;
        end else begin
          corr[j*4 +: 4] = bcd_q[s-1][j*4 +: 4];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (ready[s]) begin
        vld_q[s] <= vld_q[s-1];
      end
      if (ready[s] && vld_q[s-1]) begin
        bcd_q[s] <= {corr[BCD_W-2:0], mag_q[s-1][VALUE_BITS-1]};
        mag_q[s] <= {mag_q[s-1][VALUE_BITS-2:0], 1'b0};
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // most significant nonzero digit
  always_comb begin
    lead = '0;
    for (int j = 0; j < DIGITS; j++) begin
      if (bcd_q[STAGES-1][j*4 +: 4] != 4'd0) begin
        lead = IDX_W'(j);
      end
    end
  end

  // character serialiser with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (ready[STAGES] && vld_q[STAGES-1]) begin
        active <= 1'b1;
      end else if (emit_last) begin
        active <= 1'b0;
      end
    end
    if (active) begin
      ascii_char <= sign_pend ? sida_pkg::CHAR_MINUS
                              : (sida_pkg::CHAR_ZERO + {3'b000, cur_digit});
      last_char  <= emit_last;
    end
    if (ready[STAGES] && vld_q[STAGES-1]) begin
      ser_bcd   <= bcd_q[STAGES-1];
      idx       <= lead;
      sign_pend <= neg_q[STAGES-1];
    end else if (active) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  // text of one value leaves without gaps
  `SIDA_ASSERT_NEXT(a_text_contiguous, clk, rst, strobe && !last_char, strobe,
    "character stream broke before the last character")
  // a minus sign is never the final character
  `SIDA_ASSERT_SAME(a_sign_not_last, clk, rst,
    strobe && (ascii_char == sida_pkg::CHAR_MINUS), !last_char,
    "minus sign flagged as last character")
  // a transfer always lands in the first stage
  `SIDA_ASSERT_NEXT(a_accept_lands, clk, rst, accept, vld_q[0],
    "accepted value missing from first stage")
  // busy only when the first stage is occupied
  `SIDA_ASSERT_SAME(a_busy_full, clk, rst, busy, vld_q[0],
    "busy raised with an empty first stage")

endmodule

`default_nettype wire

>>> tb/sida_text_monitor.sv
// watches the converter's channels, predicts the decimal text of each transfer and compares
`timescale 1ns / 100ps

module sida_text_monitor #(
  parameter int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  strobe,
  input  logic [6:0]            ascii_char,
  input  logic                  last_char,
  output int                    fails,
  output int                    pending
);

  typedef struct packed {
    logic [6:0] code;
    logic       is_last;
  } text_char_t;

  text_char_t pending_chars[$];

  function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS:0] mag;
    logic [6:0]          digit;
    logic [6:0]          text[$];
    logic                negative;
    text_char_t          c;
    negative = v[VALUE_BITS-1];
    mag = negative ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    do begin
      digit = 7'(mag % 10);
      text.push_front(sida_pkg::CHAR_ZERO + digit);
      mag = mag / 10;
    end while (mag != 0);
    if (negative) begin
      text.push_front(sida_pkg::CHAR_MINUS);
    end
    foreach (text[k]) begin
      c.code = text[k];
      c.is_last = (k == text.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin : watch
    text_char_t want;
    if (!rst) begin
      if (start && !busy) begin
        predict_text(value);
      end
      if (strobe) begin
        if (pending_chars.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected char %h last %b", ascii_char, last_char);
          end
          fails++;
        end else begin
          want = pending_chars.pop_front();
          if (ascii_char !== want.code || last_char !== want.is_last) begin
            if (fails < 10) begin
              $display("char mismatch: expected %h last %b, got %h last %b",
                       want.code, want.is_last, ascii_char, last_char);
            end
            fails++;
          end
        end
      end
    end
    pending = pending_chars.size();
  end

endmodule

>>> tb/tb_signed_int_to_decimal_ascii.sv
// testbench top for the decimal text converter: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;

  localparam int VALUE_BITS   = sida_pkg::DEFAULT_VALUE_BITS;
  localparam int RANDOM_ITEMS = 200;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = VALUE_BITS + 8;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         start;
  logic signed [VALUE_BITS-1:0] value;
  logic                         busy;
  logic                         strobe;
  logic [6:0]                   ascii_char;
  logic                         last_char;
  int                           fails;
  int                           pending;
  int                           idle_cycles = 0;

  int corner_values [0:19] = '{
    0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
    999999999, 1000000000, -1000000000, 2147483647, -2147483647,
    int'(32'h80000000), int'(32'h55555555), int'(32'hAAAAAAAA), 1234567890, -123456789
  };

  always #5 clk = ~clk;

  signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  sida_text_monitor #(.VALUE_BITS(VALUE_BITS)) text_monitor (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last_char  (last_char),
    .fails      (fails),
    .pending    (pending)
  );

  // no transfer in either direction for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] v, input bit may_idle);
    int gap;
    gap = 0;
    while (may_idle && $urandom_range(0, 99) < 20) begin
      gap++;
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_text();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // magnitudes spread over every digit count, random sign
  function automatic logic [VALUE_BITS-1:0] random_value();
    longint                span;
    int                    k;
    logic [VALUE_BITS-1:0] v;
    k = $urandom_range(0, 11);
    if (k >= 10) begin
      v = VALUE_BITS'($urandom);
    end else begin
      span = 1;
      repeat (k + 1) span = span * 10;
      v = VALUE_BITS'($urandom % span);
      if ($urandom_range(0, 1) == 1) begin
        v = -v;
      end
    end
    return v;
  endfunction

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_values[i]) begin
      send_value(corner_values[i], 1'b1);
    end
    drain_text();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 130) begin
        drain_text();
      end
      send_value(random_value(), !(i >= 60 && i < 110));
    end
    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/sida_pkg.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/sida_text_monitor.sv
tb/tb_signed_int_to_decimal_ascii.sv
